>>> rtl/quadratic_probing_hash_table_macros.svh
// Assertion macros used by the checker of the hash table
`ifndef QUADRATIC_PROBING_HASH_TABLE_MACROS_SVH
`define QUADRATIC_PROBING_HASH_TABLE_MACROS_SVH

// same-cycle implication
`define QPHT_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hash table check failed");

// next-cycle implication
`define QPHT_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hash table check failed");

`endif

>>> rtl/qpht_pkg.sv
package qpht_pkg;

	localparam int DEF_TABLE_DEPTH   = 1024;
	localparam int DEF_MAX_KEY_CHARS = 8;
	localparam int CFG_RESET         = 1021;

	localparam int ACTION_W  = 2;
	localparam int KEY_W     = 64;
	localparam int KLEN_W    = 4;
	localparam int PAY_W     = 32;
	localparam int SLOT_W    = 10;
	localparam int SIZE_W    = 11;
	localparam int STATUS_W  = 3;
	localparam int COUNT_W   = 11;

	localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_COUNT  = 2'd2;
	localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd3;

	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
	localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_COUNTED  = 3'd4;
	localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd5;

	// remainder unit: top quotient bit for a key product and for a start slot
	localparam logic [3:0] TOP_PRODUCT = 4'd7;
	localparam logic [3:0] TOP_START   = 4'd9;

endpackage

>>> rtl/qpht_mod.sv
module qpht_mod #(
	parameter int SZW = 11,
	parameter int DW  = 21
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [DW-1:0]  dividend,
	input  logic [3:0]     top_bit,
	input  logic [SZW-1:0] size,
	output logic           done,
	output logic [DW-1:0]  rem
);
	localparam int SW = DW + SZW + 16;

	logic          busy_q, done_q;
	logic [3:0]    bit_q;
	logic [DW-1:0] rem_q;
	logic [SW-1:0] shifted;
	logic          ge;

	// restoring reduction, one quotient bit a cycle
	assign shifted = SW'(size) << bit_q;
	assign ge      = SW'(rem_q) >= shifted;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			bit_q  <= top_bit;
		end else if (busy_q) begin
			if (bit_q == 4'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				bit_q <= bit_q - 4'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend;
		end else if (busy_q && ge) begin
			rem_q <= rem_q - DW'(shifted);
		end
	end

	assign done = done_q;
	assign rem  = rem_q;
endmodule

>>> rtl/qpht_store.sv
module qpht_store #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int W     = 107
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [W-1:0]  wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [W-1:0]  rd_data
);
	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
endmodule

>>> rtl/quadratic_probing_hash_table.sv
// Steps: each key character folds into the home slot with one multiply (S_HMUL) and
// eight remainder steps (S_HMOD); a count reduces its start slot in the remainder unit
// (S_SMOD). Each probe is a memory read (S_RD) then a compare (S_CHK); an insert adds
// a write (S_WR), and S_DONE hands the result off. One operation at a time: the input
// stalls whenever the controller is not idle. Clear sweeps every slot; the same sweep
// runs after reset, with the input stalled until it ends. The configured size resets to 1021.
module quadratic_probing_hash_table #(
	parameter int TABLE_DEPTH   = qpht_pkg::DEF_TABLE_DEPTH,
	parameter int MAX_KEY_CHARS = qpht_pkg::DEF_MAX_KEY_CHARS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [qpht_pkg::SIZE_W-1:0]   cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [qpht_pkg::ACTION_W-1:0] action,
	input  logic [qpht_pkg::KEY_W-1:0]    key_chars,
	input  logic [qpht_pkg::KLEN_W-1:0]   key_length,
	input  logic [qpht_pkg::PAY_W-1:0]    payload,
	input  logic [qpht_pkg::SLOT_W-1:0]   start_slot,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [qpht_pkg::STATUS_W-1:0] status,
	output logic [qpht_pkg::COUNT_W-1:0]  probe_count,
	output logic [qpht_pkg::SLOT_W-1:0]   slot_found,
	output logic [qpht_pkg::SLOT_W-1:0]   home_slot,
	output logic [qpht_pkg::PAY_W-1:0]    found_payload
);
	import qpht_pkg::*;

	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int SZW   = $clog2(TABLE_DEPTH + 1);
	localparam int DW    = SZW + 10;
	localparam int EW    = 1 + KEY_W + IDX_W + PAY_W;

	typedef enum logic [8:0] {
		S_CLR  = 9'b000000001,
		S_IDLE = 9'b000000010,
		S_HMUL = 9'b000000100,
		S_HMOD = 9'b000001000,
		S_SMOD = 9'b000010000,
		S_RD   = 9'b000100000,
		S_CHK  = 9'b001000000,
		S_WR   = 9'b010000000,
		S_DONE = 9'b100000000
	} state_t;

	state_t state_q;

	logic [SIZE_W-1:0]   cfg_q;
	logic [SZW-1:0]      size;
	logic [SZW-1:0]      d_init;

	logic [ACTION_W-1:0] act_q;
	logic [KEY_W-1:0]    key_q, ks_q, knorm;
	logic [PAY_W-1:0]    pay_q;
	logic [KLEN_W-1:0]   ncnt_q, nlen;
	logic [SZW-1:0]      sum_q, h_q, sq_q, d_q, cnt_q, hval;
	logic [IDX_W-1:0]    idx_q, clr_addr_q;
	logic                clr_op_q;

	logic [STATUS_W-1:0] res_status_q;
	logic [COUNT_W-1:0]  res_count_q;
	logic [SLOT_W-1:0]   res_slot_q, res_home_q;
	logic [PAY_W-1:0]    res_pay_q;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic [COUNT_W-1:0]  out_count_q;
	logic [SLOT_W-1:0]   out_slot_q, out_home_q;
	logic [PAY_W-1:0]    out_pay_q;

	logic                mod_start, mod_done;
	logic [DW-1:0]       mod_div, mod_rem;
	logic [3:0]          mod_top;

	logic                wr_en, rd_en;
	logic [IDX_W-1:0]    wr_addr;
	logic [EW-1:0]       wr_data, rd_data;
	logic                rd_used, cont, hit, accept, out_load;
	logic [KEY_W-1:0]    rd_key;
	logic [IDX_W-1:0]    rd_home;
	logic [PAY_W-1:0]    rd_pay;

	function automatic logic [SZW-1:0] add_mod(logic [SZW-1:0] a, logic [SZW-1:0] b,
			logic [SZW-1:0] m);
		logic [SZW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= {1'b0, m}) begin
			s = s - {1'b0, m};
		end
		return s[SZW-1:0];
	endfunction

	// effective size, saturated to 2..TABLE_DEPTH
	always_comb begin
		if (int'(cfg_q) < 2) begin
			size = SZW'(2);
		end else if (int'(cfg_q) > TABLE_DEPTH) begin
			size = SZW'(TABLE_DEPTH);
		end else begin
			size = SZW'(cfg_q);
		end
	end

	assign d_init = (size > SZW'(3)) ? SZW'(3) : SZW'(3) - size;

	always_comb begin
		if (int'(key_length) > MAX_KEY_CHARS) begin
			nlen = KLEN_W'(MAX_KEY_CHARS);
		end else begin
			nlen = key_length;
		end
		for (int j = 0; j < 8; j++) begin
			knorm[63-8*j -: 8] = (j < int'(nlen)) ? key_chars[63-8*j -: 8] : 8'h00;
		end
	end

	assign cfg_ready = 1'b1;
	assign accept    = in_valid && (state_q == S_IDLE);
	assign in_stall  = (state_q != S_IDLE);
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= SIZE_W'(CFG_RESET);
		end else if (cfg_valid) begin
			cfg_q <= cfg_data;
		end
	end

	assign hval = (state_q == S_IDLE) ? SZW'(1) : SZW'(mod_rem);

	always_comb begin
		mod_start = 1'b0;
		mod_div   = DW'(sum_q) * DW'(ks_q[63:56]);
		mod_top   = TOP_PRODUCT;
		if (accept && action == ACT_COUNT) begin
			mod_start = 1'b1;
			mod_div   = DW'(start_slot);
			mod_top   = TOP_START;
		end else if (state_q == S_HMUL) begin
			mod_start = 1'b1;
		end
	end

	qpht_mod #(.SZW(SZW), .DW(DW)) u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_div),
		.top_bit  (mod_top),
		.size     (size),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign wr_en   = (state_q == S_WR) || (state_q == S_CLR);
	assign wr_addr = (state_q == S_CLR) ? clr_addr_q : idx_q;
	assign wr_data = (state_q == S_CLR) ? '0 : {1'b1, key_q, IDX_W'(h_q), pay_q};
	assign rd_en   = (state_q == S_RD);

	qpht_store #(.DEPTH(TABLE_DEPTH), .AW(IDX_W), .W(EW)) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	assign rd_used = rd_data[EW-1];
	assign rd_key  = rd_data[EW-2 -: KEY_W];
	assign rd_home = rd_data[PAY_W +: IDX_W];
	assign rd_pay  = rd_data[PAY_W-1:0];
	assign cont    = rd_used && (cnt_q < size);
	assign hit     = (act_q == ACT_SEARCH) && cont && (rd_key == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			clr_addr_q <= '0;
			clr_op_q   <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_addr_q <= clr_addr_q + IDX_W'(1);
					if (clr_addr_q == IDX_W'(TABLE_DEPTH - 1)) begin
						clr_addr_q <= '0;
						state_q    <= clr_op_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						case (action)
							ACT_CLEAR: begin
								clr_op_q <= 1'b1;
								state_q  <= S_CLR;
							end
							ACT_COUNT: state_q <= S_SMOD;
							default:   state_q <= (nlen == '0) ? S_RD : S_HMUL;
						endcase
					end
				end
				S_HMUL: state_q <= S_HMOD;
				S_HMOD: begin
					if (mod_done) begin
						state_q <= (ncnt_q == '0) ? S_RD : S_HMUL;
					end
				end
				S_SMOD: begin
					if (mod_done) begin
						state_q <= S_RD;
					end
				end
				S_RD:  state_q <= S_CHK;
				S_CHK: begin
					if (hit) begin
						state_q <= S_DONE;
					end else if (cont) begin
						state_q <= S_RD;
					end else if (act_q == ACT_INSERT && cnt_q < size) begin
						state_q <= S_WR;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_WR: state_q <= S_DONE;
				S_DONE: begin
					if (out_load) begin
						clr_op_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// operation datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				act_q        <= action;
				key_q        <= knorm;
				ks_q         <= knorm;
				pay_q        <= payload;
				ncnt_q       <= nlen;
				sum_q        <= SZW'(1);
				res_status_q <= ST_CLEARED;
				res_count_q  <= '0;
				res_slot_q   <= '0;
				res_home_q   <= '0;
				res_pay_q    <= '0;
				if (nlen == '0) begin
					h_q   <= hval;
					idx_q <= IDX_W'(hval);
					cnt_q <= SZW'(1);
					sq_q  <= SZW'(1);
					d_q   <= d_init;
				end
			end
			S_HMUL: begin
				ks_q   <= ks_q << 8;
				ncnt_q <= ncnt_q - KLEN_W'(1);
			end
			S_HMOD, S_SMOD: begin
				if (mod_done) begin
					sum_q <= hval;
					h_q   <= hval;
					idx_q <= IDX_W'(hval);
					cnt_q <= SZW'(1);
					sq_q  <= SZW'(1);
					d_q   <= d_init;
				end
			end
			S_CHK: begin
				res_count_q <= COUNT_W'(cnt_q);
				if (hit) begin
					res_status_q <= ST_FOUND;
					res_slot_q   <= SLOT_W'(idx_q);
					res_home_q   <= SLOT_W'(rd_home);
					res_pay_q    <= rd_pay;
				end else if (cont) begin
					// next probe: home + i*i, squares kept by running odd steps
					idx_q <= IDX_W'(add_mod(h_q, sq_q, size));
					sq_q  <= add_mod(sq_q, d_q, size);
					d_q   <= add_mod(d_q, SZW'(2), size);
					cnt_q <= cnt_q + SZW'(1);
				end else begin
					case (act_q)
						ACT_INSERT: begin
							res_home_q <= SLOT_W'(h_q);
							if (cnt_q < size) begin
								res_status_q <= ST_INSERTED;
								res_slot_q   <= SLOT_W'(idx_q);
							end else begin
								res_status_q <= ST_FULL;
							end
						end
						ACT_SEARCH: res_status_q <= ST_MISSING;
						default:    res_status_q <= ST_COUNTED;
					endcase
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_count_q  <= res_count_q;
			out_slot_q   <= res_slot_q;
			out_home_q   <= res_home_q;
			out_pay_q    <= res_pay_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_status_q;
	assign probe_count   = out_count_q;
	assign slot_found    = out_slot_q;
	assign home_slot     = out_home_q;
	assign found_payload = out_pay_q;
endmodule

>>> rtl/qpht_checker.sv
`include "quadratic_probing_hash_table_macros.svh"

module qpht_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [qpht_pkg::STATUS_W-1:0] status,
	input logic [qpht_pkg::COUNT_W-1:0]  probe_count,
	input logic [qpht_pkg::PAY_W-1:0]    found_payload
);
	import qpht_pkg::*;

	// a held result stays put
	`QPHT_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status))
	// one operation at a time: busy right after a transfer in
	`QPHT_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`QPHT_ASSERT_IMP(a_clear_no_probes, out_valid && status == ST_CLEARED, probe_count == '0)
	`QPHT_ASSERT_IMP(a_payload_only_found, out_valid && status != ST_FOUND, found_payload == '0)
	`QPHT_ASSERT_IMP(a_probe_nonzero, out_valid && status != ST_CLEARED, probe_count != '0)
endmodule

bind quadratic_probing_hash_table qpht_checker u_qpht_checker (.*);
